>>> rtl/core/spct_pkg.sv
// shared types and constants for the shape pair collision test
// no dependencies

package spct_pkg;

  localparam logic KIND_RECT   = 1'b0;
  localparam logic KIND_CIRCLE = 1'b1;

  typedef enum logic [1:0] {
    MODE_RR = 2'b00,
    MODE_CC = 2'b01,
    MODE_RC = 2'b10
  } mode_t;

  typedef struct packed {
    logic               a_kind;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic [14:0]        a_extent;
    logic [14:0]        a_height;
    logic               b_kind;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic [14:0]        b_extent;
    logic [14:0]        b_height;
  } pair_t;

  // after differences and role selection
  typedef struct packed {
    mode_t       mode;
    logic        rr_hit;
    logic [15:0] adx;
    logic [15:0] ady;
    logic [14:0] w;
    logic [14:0] h;
    logic [14:0] r;
    logic [15:0] rsum;
  } s1_t;

  // early decision or squared-distance operands
  typedef struct packed {
    logic        decided;
    logic        hit;
    logic        strict;
    logic [15:0] m1;
    logic [15:0] m2;
    logic [15:0] m3;
  } s2_t;

  typedef struct packed {
    logic        decided;
    logic        hit;
    logic        strict;
    logic [31:0] sq1;
    logic [31:0] sq2;
    logic [31:0] sq3;
  } s3_t;

endpackage

>>> rtl/core/spct_if.sv
// valid/ready channels for shape pairs and collision results
// depends on nothing

interface spct_pair_if;
  logic               valid;
  logic               ready;
  logic               a_kind;
  logic signed [15:0] a_x;
  logic signed [15:0] a_y;
  logic [14:0]        a_extent;
  logic [14:0]        a_height;
  logic               b_kind;
  logic signed [15:0] b_x;
  logic signed [15:0] b_y;
  logic [14:0]        b_extent;
  logic [14:0]        b_height;

  modport source (
    output valid, a_kind, a_x, a_y, a_extent, a_height,
    output b_kind, b_x, b_y, b_extent, b_height,
    input  ready
  );
  modport sink (
    input  valid, a_kind, a_x, a_y, a_extent, a_height,
    input  b_kind, b_x, b_y, b_extent, b_height,
    output ready
  );
endinterface

interface spct_result_if;
  logic valid;
  logic ready;
  logic collided;

  modport source (output valid, collided, input ready);
  modport sink (input valid, collided, output ready);
endinterface

>>> rtl/core/spct_reduce.sv
// early-out tests and multiplier operand selection for one pair
// depends on spct_pkg

module spct_reduce (
  input  spct_pkg::s1_t s1,
  output spct_pkg::s2_t s2
);

  logic [16:0] dx2;
  logic [16:0] dy2;
  logic [15:0] r2;
  logic [16:0] wr;
  logic [16:0] hr;
  logic [16:0] w17;
  logic [16:0] h17;
  logic [15:0] ex;
  logic [15:0] ey;
  logic        far;
  logic        covered;

  // doubled distances keep the half extents exact
  assign dx2     = {s1.adx, 1'b0};
  assign dy2     = {s1.ady, 1'b0};
  assign r2      = {s1.r, 1'b0};
  assign w17     = {2'b00, s1.w};
  assign h17     = {2'b00, s1.h};
  assign wr      = w17 + {1'b0, r2};
  assign hr      = h17 + {1'b0, r2};
  assign far     = (dx2 > wr) || (dy2 > hr);
  assign covered = (dx2 <= w17) || (dy2 <= h17);
  assign ex      = 16'(dx2 - w17);
  assign ey      = 16'(dy2 - h17);

  always_comb begin
    s2.decided = 1'b1;
    s2.hit     = 1'b0;
    s2.strict  = 1'b0;
    s2.m1      = '0;
    s2.m2      = '0;
    s2.m3      = '0;
    case (s1.mode)
      spct_pkg::MODE_RR: begin
        s2.hit = s1.rr_hit;
      end
      spct_pkg::MODE_CC: begin
        s2.decided = 1'b0;
        s2.strict  = 1'b1;
        s2.m1      = s1.adx;
        s2.m2      = s1.ady;
        s2.m3      = s1.rsum;
      end
      spct_pkg::MODE_RC: begin
        if (far) begin
          s2.hit = 1'b0;
        end else if (covered) begin
          s2.hit = 1'b1;
        end else begin
          // corner distance, both offsets bounded by the doubled radius
          s2.decided = 1'b0;
          s2.m1      = ex;
          s2.m2      = ey;
          s2.m3      = r2;
        end
      end
      default: begin
        s2.hit = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/core/shape_pair_collision_test_core.sv
// shape pair collision test: one rectangle/circle pair in, one overlap flag out
// stages: input register, differences, early outs, squares, sum and compare
// each stage stalls only when full and blocked, so bubbles fill under backpressure
// reset clears all stage valids; payload registers are not reset
// depends on spct_pkg, spct_if and spct_reduce

module shape_pair_collision_test_core (
  input  logic          clk,
  input  logic          rst,
  spct_pair_if.sink     pair,
  spct_result_if.source result
);

  logic v0, v1, v2, v3, vo;
  logic rdy0, rdy1, rdy2, rdy3, rdyo;

  spct_pkg::pair_t s0;
  spct_pkg::pair_t s0_next;
  spct_pkg::s1_t   s1;
  spct_pkg::s1_t   s1_next;
  spct_pkg::s2_t   s2;
  spct_pkg::s2_t   s2_next;
  spct_pkg::s3_t   s3;
  logic            collided;
  logic            collided_next;

  logic signed [16:0] ax, ay, bx, by;
  logic signed [16:0] dx, dy;
  logic        [15:0] ndx, ndy;
  logic signed [16:0] aw, ah, bw, bh;
  logic [32:0]        sq_sum;
  logic               near;

  // ready chain
  assign rdyo = !vo || result.ready;
  assign rdy3 = !v3 || rdyo;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;

  assign pair.ready      = rdy0;
  assign result.valid    = vo;
  assign result.collided = collided;

  assign s0_next = '{
    a_kind:   pair.a_kind,
    a_x:      pair.a_x,
    a_y:      pair.a_y,
    a_extent: pair.a_extent,
    a_height: pair.a_height,
    b_kind:   pair.b_kind,
    b_x:      pair.b_x,
    b_y:      pair.b_y,
    b_extent: pair.b_extent,
    b_height: pair.b_height
  };

  // stage 1: differences, rectangle overlap, role selection
  assign ax  = $signed({s0.a_x[15], s0.a_x});
  assign ay  = $signed({s0.a_y[15], s0.a_y});
  assign bx  = $signed({s0.b_x[15], s0.b_x});
  assign by  = $signed({s0.b_y[15], s0.b_y});
  assign aw  = $signed({2'b00, s0.a_extent});
  assign ah  = $signed({2'b00, s0.a_height});
  assign bw  = $signed({2'b00, s0.b_extent});
  assign bh  = $signed({2'b00, s0.b_height});
  assign dx  = ax - bx;
  assign dy  = ay - by;
  assign ndx = 16'(-dx);
  assign ndy = 16'(-dy);

  always_comb begin
    if (s0.a_kind == spct_pkg::KIND_RECT && s0.b_kind == spct_pkg::KIND_RECT) begin
      s1_next.mode = spct_pkg::MODE_RR;
    end else if (s0.a_kind == spct_pkg::KIND_CIRCLE && s0.b_kind == spct_pkg::KIND_CIRCLE) begin
      s1_next.mode = spct_pkg::MODE_CC;
    end else begin
      s1_next.mode = spct_pkg::MODE_RC;
    end
    s1_next.rr_hit = (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);
    s1_next.adx    = dx[16] ? ndx : dx[15:0];
    s1_next.ady    = dy[16] ? ndy : dy[15:0];
    s1_next.rsum   = {1'b0, s0.a_extent} + {1'b0, s0.b_extent};
    if (s0.a_kind == spct_pkg::KIND_RECT) begin
      s1_next.w = s0.a_extent;
      s1_next.h = s0.a_height;
      s1_next.r = s0.b_extent;
    end else begin
      s1_next.w = s0.b_extent;
      s1_next.h = s0.b_height;
      s1_next.r = s0.a_extent;
    end
  end

  // stage 2
  spct_reduce u_reduce (
    .s1 (s1),
    .s2 (s2_next)
  );

  // stage 4: sum of squares against squared radius, or the early decision
  assign sq_sum = {1'b0, s3.sq1} + {1'b0, s3.sq2};
  assign near = s3.strict ? (sq_sum < {1'b0, s3.sq3}) : (sq_sum <= {1'b0, s3.sq3});
  assign collided_next = s3.decided ? s3.hit : near;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (rdy0) v0 <= pair.valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdyo) vo <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) s0 <= s0_next;
    if (rdy1) s1 <= s1_next;
    if (rdy2) s2 <= s2_next;
    if (rdy3) begin
      s3.decided <= s2.decided;
      s3.hit     <= s2.hit;
      s3.strict  <= s2.strict;
      s3.sq1     <= 32'(s2.m1) * 32'(s2.m1);
      s3.sq2     <= 32'(s2.m2) * 32'(s2.m2);
      s3.sq3     <= 32'(s2.m3) * 32'(s2.m3);
    end
    if (rdyo) collided <= collided_next;
  end

  // input stalls only when every stage holds a word
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !pair.ready |-> (v0 && v1 && v2 && v3 && vo))
    else $error("input stalled with a free stage");

  // rectangle pairs are decided before the multipliers
  a_rr_decided: assert property (@(posedge clk) disable iff (rst)
    (v1 && s1.mode == spct_pkg::MODE_RR) |-> s2_next.decided)
    else $error("rectangle pair left undecided");

  // corner offsets stay within the doubled radius
  a_corner_bound: assert property (@(posedge clk) disable iff (rst)
    (v2 && !s2.decided && !s2.strict) |-> (s2.m1 <= s2.m3 && s2.m2 <= s2.m3))
    else $error("corner offset exceeds doubled radius");

endmodule
